@@ src/ip_acl_longest_prefix_match_macros.svh @@
// Assertion macros for the IPv4 filter table block.
// Used by the port checker; no other dependencies.
`ifndef IP_ACL_LONGEST_PREFIX_MATCH_MACROS_SVH
`define IP_ACL_LONGEST_PREFIX_MATCH_MACROS_SVH

// Clocked property, switched off while reset is high
`define IPACL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked property that also holds during reset
`define IPACL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

@@ src/ipacl_pkg.sv @@
// Shared types and constants for the IPv4 filter table block.
// No dependencies.
package ipacl_pkg;

   localparam int MaxEntries    = 16;
   localparam int SlotWidth     = 4;
   localparam int CountWidth    = 5;
   localparam int DomainWidth   = 9;
   localparam int PrefixWidth   = 6;
   localparam int RangeWidth    = 16;
   localparam int AddrWidth     = 32;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 5;

   localparam logic [DomainWidth-1:0] AnyDomain  = 9'h1ff;
   localparam logic [PrefixWidth-1:0] FullPrefix = 6'd32;

   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ENTRY_COUNT    = 2'd0,
      CSR_DEFAULT_ACCEPT = 2'd1
   } csr_index_type;

   // One item travelling down the cell chain, with the best match so far
   typedef struct packed {
      logic                   valid;
      func_type               func;
      logic [SlotWidth-1:0]   entry_index;
      logic [DomainWidth-1:0] entry_domain;
      logic [PrefixWidth-1:0] entry_prefix;
      logic                   entry_deny;
      logic [RangeWidth-1:0]  entry_range;
      logic [AddrWidth-1:0]   entry_address;
      logic [AddrWidth-1:0]   entry_netmask;
      logic [DomainWidth-1:0] query_domain;
      logic                   query_any_domain;
      logic [AddrWidth-1:0]   query_address;
      logic                   best_hit;
      logic [SlotWidth-1:0]   best_index;
      logic [PrefixWidth-1:0] best_prefix;
      logic                   best_deny;
   } item_type;

endpackage

@@ src/ipacl_if.sv @@
// Channel interfaces for requests and responses of the filter table.
// Depends on ipacl_pkg.
interface ipacl_req_if import ipacl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [SlotWidth-1:0]   entry_index;
   logic [DomainWidth-1:0] entry_domain;
   logic [PrefixWidth-1:0] entry_prefix;
   logic                   entry_deny;
   logic [RangeWidth-1:0]  entry_range;
   logic [AddrWidth-1:0]   entry_address;
   logic [AddrWidth-1:0]   entry_netmask;
   logic [DomainWidth-1:0] query_domain;
   logic                   query_any_domain;
   logic [AddrWidth-1:0]   query_address;

   modport source (
      output valid, func, entry_index, entry_domain, entry_prefix, entry_deny,
             entry_range, entry_address, entry_netmask, query_domain,
             query_any_domain, query_address,
      input  ready
   );
   modport sink (
      input  valid, func, entry_index, entry_domain, entry_prefix, entry_deny,
             entry_range, entry_address, entry_netmask, query_domain,
             query_any_domain, query_address,
      output ready
   );
endinterface

interface ipacl_rsp_if import ipacl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 accepted;
   logic                 hit;
   logic [SlotWidth-1:0] hit_index;

   modport source (output valid, accepted, hit, hit_index, input ready);
   modport sink (input valid, accepted, hit, hit_index, output ready);
endinterface

@@ src/ipacl_cell.sv @@
// One table cell: holds a single filter entry and one chain stage.
// Depends on ipacl_pkg.
module ipacl_cell import ipacl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [SlotWidth-1:0]  cell_index,
   input  logic [CountWidth-1:0] entry_count,
   input  item_type              item_i,
   output item_type              item_o
);

   logic [AddrWidth-1:0]   addr_ff, addr_in;
   logic [AddrWidth-1:0]   mask_ff, mask_in;
   logic [DomainWidth-1:0] dom_ff, dom_in;
   logic [PrefixWidth-1:0] prefix_ff, prefix_in;
   logic                   deny_ff, deny_in;
   logic [RangeWidth-1:0]  range_ff, range_in;
   item_type               item_ff, item_in;

   logic                 is_lookup;
   logic                 in_use;
   logic                 dom_ok;
   logic                 addr_match;
   logic                 take;
   logic [AddrWidth:0]   upper_bound;

   assign is_lookup = (item_i.func == FUNC_LOOKUP);

   // entry write when a write transfer for this slot passes
   always_comb begin
      addr_in   = addr_ff;
      mask_in   = mask_ff;
      dom_in    = dom_ff;
      prefix_in = prefix_ff;
      deny_in   = deny_ff;
      range_in  = range_ff;
      if (advance && item_i.valid && !is_lookup && item_i.entry_index == cell_index) begin
         addr_in   = item_i.entry_address;
         mask_in   = item_i.entry_netmask;
         dom_in    = item_i.entry_domain;
         prefix_in = item_i.entry_prefix;
         deny_in   = item_i.entry_deny;
         range_in  = item_i.entry_range;
      end
   end

   // match test against the stored entry; bound in 33 bits, no wrap
   assign upper_bound = {1'b0, addr_ff} + {{(AddrWidth+1-RangeWidth){1'b0}}, range_ff};
   assign in_use      = entry_count > {{(CountWidth-SlotWidth){1'b0}}, cell_index};
   assign dom_ok      = item_i.query_any_domain || dom_ff == AnyDomain ||
                        dom_ff == item_i.query_domain;

   always_comb begin
      if (prefix_ff < FullPrefix) begin
         addr_match = (item_i.query_address & mask_ff) == addr_ff;
      end else if (range_ff == '0) begin
         addr_match = item_i.query_address == addr_ff;
      end else begin
         addr_match = item_i.query_address >= addr_ff &&
                      {1'b0, item_i.query_address} <= upper_bound;
      end
   end

   // longer prefix replaces; earlier slot keeps ties
   assign take = is_lookup && in_use && dom_ok && addr_match &&
                 (!item_i.best_hit || prefix_ff > item_i.best_prefix);

   always_comb begin
      item_in = item_ff;
      if (advance) begin
         item_in = item_i;
         if (take) begin
            item_in.best_hit    = 1'b1;
            item_in.best_index  = cell_index;
            item_in.best_prefix = prefix_ff;
            item_in.best_deny   = deny_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      mask_ff   <= mask_in;
      dom_ff    <= dom_in;
      prefix_ff <= prefix_in;
      deny_ff   <= deny_in;
      range_ff  <= range_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= '0;
      end else begin
         item_ff <= item_in;
      end
   end

   assign item_o = item_ff;

endmodule

@@ src/ip_acl_longest_prefix_match.sv @@
// IPv4 allow/deny filter table with longest-prefix selection.
// A lookup result passes through the register of every table cell and then the response register.
// Throughput: one item per cycle while no response waits; a cell per slot tests each passing lookup.
// A response not taken stalls the whole cell chain and the request side.
// Reset (synchronous): chain empty, entry_count 0, default_accept 1; entries undefined.
// Depends on ipacl_pkg, ipacl_if and ipacl_cell.
module ip_acl_longest_prefix_match import ipacl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   ipacl_req_if.sink                req_ch,
   ipacl_rsp_if.source              rsp_ch,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data
);

   logic [CountWidth-1:0] entry_count_ff, entry_count_in;
   logic                  default_accept_ff, default_accept_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_accepted_ff, rsp_accepted_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [SlotWidth-1:0]  rsp_hit_index_ff, rsp_hit_index_in;

   logic     advance;
   item_type head;
   item_type chain [0:MaxEntries];
   item_type last;

   // chain moves unless a response waits
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // configuration registers
   always_comb begin
      entry_count_in    = entry_count_ff;
      default_accept_in = default_accept_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT:    entry_count_in    = csr_write_data[CountWidth-1:0];
            CSR_DEFAULT_ACCEPT: default_accept_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff    <= '0;
         default_accept_ff <= 1'b1;
      end else begin
         entry_count_ff    <= entry_count_in;
         default_accept_ff <= default_accept_in;
      end
   end

   // chain head from the request channel
   always_comb begin
      head                  = '0;
      head.valid            = req_ch.valid;
      head.func             = func_type'(req_ch.func);
      head.entry_index      = req_ch.entry_index;
      head.entry_domain     = req_ch.entry_domain;
      head.entry_prefix     = req_ch.entry_prefix;
      head.entry_deny       = req_ch.entry_deny;
      head.entry_range      = req_ch.entry_range;
      head.entry_address    = req_ch.entry_address;
      head.entry_netmask    = req_ch.entry_netmask;
      head.query_domain     = req_ch.query_domain;
      head.query_any_domain = req_ch.query_any_domain;
      head.query_address    = req_ch.query_address;
   end

   assign chain[0] = head;

   for (genvar k = 0; k < MaxEntries; k++) begin : g_cell
      ipacl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .cell_index  (SlotWidth'(k)),
         .entry_count (entry_count_ff),
         .item_i      (chain[k]),
         .item_o      (chain[k+1])
      );
   end

   assign last = chain[MaxEntries];

   // response register; writes leave the chain without a response
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_accepted_in  = rsp_accepted_ff;
      rsp_hit_in       = rsp_hit_ff;
      rsp_hit_index_in = rsp_hit_index_ff;
      if (advance) begin
         rsp_valid_in     = last.valid && last.func == FUNC_LOOKUP;
         rsp_hit_in       = last.best_hit;
         rsp_accepted_in  = last.best_hit ? !last.best_deny : default_accept_ff;
         rsp_hit_index_in = last.best_hit ? last.best_index : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_accepted_ff  <= rsp_accepted_in;
      rsp_hit_ff       <= rsp_hit_in;
      rsp_hit_index_ff <= rsp_hit_index_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.accepted  = rsp_accepted_ff;
   assign rsp_ch.hit       = rsp_hit_ff;
   assign rsp_ch.hit_index = rsp_hit_index_ff;

endmodule

@@ src/ipacl_checker.sv @@
// Port-level checker for the IPv4 filter table, bound to the top level.
// Depends on ipacl_pkg and the assertion macro header.
`include "ip_acl_longest_prefix_match_macros.svh"

module ipacl_checker import ipacl_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_hit,
   input logic [SlotWidth-1:0] rsp_hit_index
);

   // a stalled response stays offered
   `IPACL_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped while stalled")

   // request side is open exactly when the response stage can move
   `IPACL_ASSERT(a_ready_link, clock, reset, req_ready == (!rsp_valid || rsp_ready), "req ready out of step with rsp stage")

   // a default answer carries slot zero
   `IPACL_ASSERT(a_miss_index, clock, reset, rsp_valid && !rsp_hit |-> rsp_hit_index == '0, "nonzero hit_index without hit")

   // reset empties the response stage
   `IPACL_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind ip_acl_longest_prefix_match ipacl_checker u_ipacl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_hit       (rsp_ch.hit),
   .rsp_hit_index (rsp_ch.hit_index)
);

@@ tb/ip_acl_longest_prefix_match_tb.sv @@
// Testbench for the IPv4 filter table with longest-prefix selection.
// Drives table writes and lookups, checks every response against a local predictor.
// Depends on ipacl_pkg, ipacl_if and the ip_acl_longest_prefix_match RTL.
`timescale 1ns / 1ps

module ip_acl_longest_prefix_match_tb;
   import ipacl_pkg::*;

   // Register indexes that map to nothing in the block
   localparam logic [CsrIndexWidth-1:0] CsrSpareLow  = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CsrSpareHigh = 2'd3;
   // Cell chain depth plus margin, used when the chain must be empty
   localparam int SettleCycles = MaxEntries + 6;
   localparam int TimeoutNs    = 4_000_000;

   typedef struct {
      func_type               func;
      logic [SlotWidth-1:0]   slot;
      logic [DomainWidth-1:0] entry_domain;
      logic [PrefixWidth-1:0] entry_prefix;
      logic                   entry_deny;
      logic [RangeWidth-1:0]  entry_range;
      logic [AddrWidth-1:0]   entry_address;
      logic [AddrWidth-1:0]   entry_netmask;
      logic [DomainWidth-1:0] query_domain;
      logic                   query_any_domain;
      logic [AddrWidth-1:0]   query_address;
   } acl_req_type;

   typedef struct packed {
      logic                 accepted;
      logic                 hit;
      logic [SlotWidth-1:0] hit_index;
   } verdict_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_write_data;

   ipacl_req_if req_bus ();
   ipacl_rsp_if rsp_bus ();

   ip_acl_longest_prefix_match DUT (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predicted table and registers
   logic [DomainWidth-1:0] acl_domain  [MaxEntries];
   logic [PrefixWidth-1:0] acl_prefix  [MaxEntries];
   logic                   acl_deny    [MaxEntries];
   logic [RangeWidth-1:0]  acl_range   [MaxEntries];
   logic [AddrWidth-1:0]   acl_address [MaxEntries];
   logic [AddrWidth-1:0]   acl_netmask [MaxEntries];
   logic [CountWidth-1:0]  cfg_count   = '0;
   logic                   cfg_default = 1'b1;

   verdict_type pending_verdicts[$];
   int          errors       = 0;
   int          hold_request = 0;
   bit          send_steady  = 1'b0;
   bit          rsp_steady   = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #(TimeoutNs);
      $display("DONE: errors detected");
      $finish;
   end

   // Idle length: mostly short, now and then long
   function automatic int idle_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
   endfunction

   // Longest-prefix decision over the live slots
   function automatic verdict_type lpm_classify(input logic [DomainWidth-1:0] qdom,
                                                input logic any_dom,
                                                input logic [AddrWidth-1:0] qaddr);
      verdict_type            v;
      int                     live;
      int                     top_slot;
      logic                   found;
      logic                   matched;
      logic [PrefixWidth-1:0] top_prefix;
      live       = (cfg_count > MaxEntries) ? MaxEntries : cfg_count;
      found      = 1'b0;
      top_slot   = 0;
      top_prefix = '0;
      for (int k = 0; k < live; k++) begin
         if (!any_dom && acl_domain[k] != AnyDomain && acl_domain[k] != qdom)
            continue;
         if (acl_prefix[k] < FullPrefix)
            matched = ((qaddr & acl_netmask[k]) == acl_address[k]);
         else if (acl_range[k] == '0)
            matched = (qaddr == acl_address[k]);
         else
            // upper bound kept in 33 bits so it cannot wrap
            matched = (qaddr >= acl_address[k]) &&
                      ({1'b0, qaddr} <= {1'b0, acl_address[k]} + 33'(acl_range[k]));
         if (matched && (!found || acl_prefix[k] > top_prefix)) begin
            found      = 1'b1;
            top_slot   = k;
            top_prefix = acl_prefix[k];
         end
      end
      v.hit       = found;
      v.accepted  = found ? ~acl_deny[top_slot] : cfg_default;
      v.hit_index = found ? SlotWidth'(top_slot) : '0;
      return v;
   endfunction

   function automatic acl_req_type make_write(input logic [SlotWidth-1:0] slot,
                                              input logic [DomainWidth-1:0] dom,
                                              input logic [PrefixWidth-1:0] plen,
                                              input logic deny,
                                              input logic [RangeWidth-1:0] span,
                                              input logic [AddrWidth-1:0] base,
                                              input logic [AddrWidth-1:0] mask);
      acl_req_type it;
      it.func             = FUNC_WRITE;
      it.slot             = slot;
      it.entry_domain     = dom;
      it.entry_prefix     = plen;
      it.entry_deny       = deny;
      it.entry_range      = span;
      it.entry_address    = base;
      it.entry_netmask    = mask;
      it.query_domain     = DomainWidth'($urandom);
      it.query_any_domain = 1'($urandom_range(0, 1));
      it.query_address    = $urandom;
      return it;
   endfunction

   function automatic acl_req_type make_lookup(input logic [DomainWidth-1:0] dom,
                                               input logic any_dom,
                                               input logic [AddrWidth-1:0] addr);
      acl_req_type it;
      it = make_write(SlotWidth'($urandom), DomainWidth'($urandom), PrefixWidth'($urandom),
                      1'($urandom), RangeWidth'($urandom), $urandom, $urandom);
      it.func             = FUNC_LOOKUP;
      it.query_domain     = dom;
      it.query_any_domain = any_dom;
      it.query_address    = addr;
      return it;
   endfunction

   // Random table entry: masked prefixes, exact hosts, ranges, oversized prefixes
   function automatic acl_req_type rand_entry(input logic [SlotWidth-1:0] slot);
      logic [PrefixWidth-1:0] plen;
      logic [AddrWidth-1:0]   mask;
      logic [AddrWidth-1:0]   base;
      logic [DomainWidth-1:0] dom;
      logic [RangeWidth-1:0]  span;
      int                     kind;
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
         0: dom = AnyDomain;
         1: dom = DomainWidth'($urandom_range(0, 3));
         default: dom = DomainWidth'($urandom);
      endcase
      span = RangeWidth'($urandom);
      base = $urandom;
      mask = $urandom;
      if (kind < 5) begin
         plen = PrefixWidth'($urandom_range(0, 31));
         // mostly a proper netmask; sometimes a random mask and base
         if (kind != 0) begin
            mask = ~(32'hffff_ffff >> plen);
            base = base & mask;
         end
      end else if (kind < 7) begin
         plen = FullPrefix;
         span = '0;
      end else if (kind < 9) begin
         plen = FullPrefix;
         if ($urandom_range(0, 3) == 0)
            base = 32'hffff_ffff - $urandom_range(0, 65535);
      end else begin
         plen = PrefixWidth'($urandom_range(33, 63));
         if ($urandom_range(0, 1) == 0)
            span = '0;
      end
      return make_write(slot, dom, plen, 1'($urandom_range(0, 1)), span, base, mask);
   endfunction

   // Random lookup, usually aimed at some slot's address space
   function automatic acl_req_type rand_lookup();
      int                     k;
      logic [AddrWidth-1:0]   addr;
      logic [DomainWidth-1:0] dom;
      k    = $urandom_range(0, MaxEntries - 1);
      addr = $urandom;
      if ($urandom_range(0, 4) != 0) begin
         if (acl_prefix[k] < FullPrefix)
            addr = (acl_address[k] & acl_netmask[k]) | (addr & ~acl_netmask[k]);
         else if (acl_range[k] == '0)
            addr = acl_address[k] + (($urandom_range(0, 3) == 0) ? 32'd1 : 32'd0);
         else
            addr = acl_address[k] + 32'($urandom_range(0, acl_range[k] + 1))
                   - (($urandom_range(0, 7) == 0) ? 32'd1 : 32'd0);
      end
      case ($urandom_range(0, 3))
         0: dom = acl_domain[k];
         1: dom = DomainWidth'($urandom_range(0, 3));
         2: dom = AnyDomain;
         default: dom = DomainWidth'($urandom);
      endcase
      return make_lookup(dom, $urandom_range(0, 3) == 0, addr);
   endfunction

   // Offer one item, wait for its transfer, then update the prediction
   task automatic send_item(input acl_req_type it);
      int gap;
      gap = send_steady ? 0 : (($urandom_range(0, 2) == 0) ? idle_length() : 0);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.func             <= it.func;
      req_bus.entry_index      <= it.slot;
      req_bus.entry_domain     <= it.entry_domain;
      req_bus.entry_prefix     <= it.entry_prefix;
      req_bus.entry_deny       <= it.entry_deny;
      req_bus.entry_range      <= it.entry_range;
      req_bus.entry_address    <= it.entry_address;
      req_bus.entry_netmask    <= it.entry_netmask;
      req_bus.query_domain     <= it.query_domain;
      req_bus.query_any_domain <= it.query_any_domain;
      req_bus.query_address    <= it.query_address;
      do @(posedge clock); while (!req_bus.ready);
      if (it.func == FUNC_WRITE) begin
         acl_domain[it.slot]  = it.entry_domain;
         acl_prefix[it.slot]  = it.entry_prefix;
         acl_deny[it.slot]    = it.entry_deny;
         acl_range[it.slot]   = it.entry_range;
         acl_address[it.slot] = it.entry_address;
         acl_netmask[it.slot] = it.entry_netmask;
      end else begin
         pending_verdicts.push_back(lpm_classify(it.query_domain, it.query_any_domain,
                                                 it.query_address));
      end
   endtask

   // Stop offering, wait for every response, then let trailing writes leave the chain
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_ENTRY_COUNT:    cfg_count = data;
         CSR_DEFAULT_ACCEPT: cfg_default = data[0];
         default: ;
      endcase
   endtask

   // Response side: random stalls, requested hold-offs, and the check of each transfer
   initial begin
      int          stall_left;
      verdict_type exp;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_verdicts.size() == 0) begin
               $error("response transfer with no lookup outstanding");
               errors++;
            end else begin
               exp = pending_verdicts.pop_front();
               if (rsp_bus.accepted !== exp.accepted) begin
                  $error("accepted: expected %0d, actual %0d", exp.accepted, rsp_bus.accepted);
                  errors++;
               end
               if (rsp_bus.hit !== exp.hit) begin
                  $error("hit: expected %0d, actual %0d", exp.hit, rsp_bus.hit);
                  errors++;
               end
               if (rsp_bus.hit_index !== exp.hit_index) begin
                  $error("hit_index: expected %0d, actual %0d", exp.hit_index,
                         rsp_bus.hit_index);
                  errors++;
               end
            end
         end
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && !rsp_steady && $urandom_range(0, 3) == 0) begin
            stall_left = idle_length();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Empty table: every lookup gets the default answer, both polarities
   task automatic test_default_answer();
      send_item(make_lookup('0, 1'b0, '0));
      send_item(make_lookup(AnyDomain, 1'b1, 32'hffff_ffff));
      send_item(make_lookup(DomainWidth'($urandom), 1'b0, $urandom));
      wait_idle();
      csr_write(CSR_DEFAULT_ACCEPT, 5'b11110);
      send_item(make_lookup(9'h0aa, 1'b1, 32'h5555_5555));
      send_item(make_lookup(9'h155, 1'b0, 32'haaaa_aaaa));
      wait_idle();
      csr_write(CSR_DEFAULT_ACCEPT, 5'b00001);
   endtask

   // Fixed table layout exercising overlaps, ties, ranges and odd prefixes
   task automatic test_load_table();
      send_item(make_write(4'd0,  AnyDomain, 6'd0,  1'b0, 16'h0,    32'h0,         32'h0));
      send_item(make_write(4'd1,  9'd5,      6'd8,  1'b1, 16'h0,    32'h0a00_0000, 32'hff00_0000));
      send_item(make_write(4'd2,  9'd5,      6'd16, 1'b0, 16'h0,    32'h0a01_0000, 32'hffff_0000));
      send_item(make_write(4'd3,  AnyDomain, 6'd32, 1'b1, 16'h0,    32'h0a01_0203, 32'h0));
      // range whose top bound lies above 32 bits
      send_item(make_write(4'd4,  9'd7,      6'd32, 1'b0, 16'hffff, 32'hffff_ff00, 32'h0));
      send_item(make_write(4'd5,  AnyDomain, 6'd24, 1'b1, 16'h0,    32'hc0a8_0100, 32'hffff_ff00));
      send_item(make_write(4'd6,  AnyDomain, 6'd24, 1'b0, 16'h0,    32'hc0a8_0100, 32'hffff_ff00));
      send_item(make_write(4'd7,  9'd0,      6'd63, 1'b0, 16'h0010, 32'hc0a8_0105, 32'hffff_ffff));
      send_item(make_write(4'd8,  AnyDomain, 6'd33, 1'b1, 16'h0,    32'hc0a8_0105, 32'h0));
      send_item(make_write(4'd9,  AnyDomain, 6'd31, 1'b1, 16'h0,    32'h0,         32'hffff_fffe));
      send_item(make_write(4'd10, 9'h1fe,    6'd32, 1'b0, 16'h0,    32'hffff_ffff, 32'hffff_ffff));
      send_item(make_write(4'd11, 9'd0,      6'd32, 1'b1, 16'h0005, 32'h0,         32'h0));
      // base with bits outside its mask: the masked compare never hits
      send_item(make_write(4'd12, AnyDomain, 6'd16, 1'b1, 16'h0,    32'h0a01_ffff, 32'hffff_0000));
      // range is ignored under a masked compare
      send_item(make_write(4'd13, 9'd3,      6'd20, 1'b1, 16'hffff, 32'hac10_0000, 32'hffff_f000));
      send_item(make_write(4'd14, AnyDomain, 6'd0,  1'b1, 16'h0,    32'h0,         32'h0));
      send_item(rand_entry(4'd15));
      wait_idle();
      csr_write(CSR_ENTRY_COUNT, 5'd16);
   endtask

   task automatic test_priority_cases();
      send_item(make_lookup(9'd5,   1'b0, 32'h0a01_0203));
      send_item(make_lookup(9'd5,   1'b0, 32'h0a01_0204));
      send_item(make_lookup(9'd5,   1'b0, 32'h0a02_0000));
      send_item(make_lookup(9'd6,   1'b0, 32'h0a02_0000));
      send_item(make_lookup(9'd6,   1'b1, 32'h0a02_0000));
      send_item(make_lookup(9'd7,   1'b0, 32'hffff_ff80));
      send_item(make_lookup(9'd7,   1'b0, 32'hffff_ffff));
      send_item(make_lookup(9'h1fe, 1'b0, 32'hffff_ffff));
      send_item(make_lookup(9'd0,   1'b0, 32'h0000_0003));
      send_item(make_lookup(9'd1,   1'b0, 32'h0000_0001));
      send_item(make_lookup(9'd0,   1'b0, 32'hc0a8_0105));
      send_item(make_lookup(9'd1,   1'b0, 32'hc0a8_0105));
      send_item(make_lookup(9'd1,   1'b0, 32'hc0a8_0107));
      send_item(make_lookup(9'd3,   1'b0, 32'hac10_0abc));
      send_item(make_lookup(AnyDomain, 1'b0, 32'h0a01_ffff));
      wait_idle();
   endtask

   // entry_count of one, above the table size, and back to full
   task automatic test_count_limits();
      csr_write(CSR_ENTRY_COUNT, 5'd1);
      send_item(make_lookup(9'd5, 1'b0, 32'h0a01_0203));
      wait_idle();
      csr_write(CSR_ENTRY_COUNT, 5'd31);
      send_item(make_lookup(9'd5, 1'b0, 32'h0a01_0203));
      wait_idle();
      csr_write(CSR_ENTRY_COUNT, 5'd17);
      send_item(make_lookup(9'd7, 1'b0, 32'hffff_ffff));
      wait_idle();
      csr_write(CSR_ENTRY_COUNT, 5'd16);
   endtask

   // Writes to unmapped indexes leave both registers alone
   task automatic test_spare_registers();
      csr_write(CsrSpareLow, 5'h1f);
      csr_write(CsrSpareHigh, 5'h00);
      send_item(make_lookup(9'd5, 1'b0, 32'h0a02_0000));
      send_item(make_lookup(9'd9, 1'b0, 32'h1234_5678));
      wait_idle();
   endtask

   // Phases of mixed table updates and lookups under varying settings
   task automatic test_random_traffic();
      logic [CountWidth-1:0] count;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: count = 5'd16;
            1: count = 5'd31;
            2: count = 5'd0;
            3: count = CountWidth'($urandom_range(1, 15));
            default: count = CountWidth'($urandom_range(0, 31));
         endcase
         csr_write(CSR_ENTRY_COUNT, count);
         csr_write(CSR_DEFAULT_ACCEPT, CsrDataWidth'($urandom_range(0, 31)));
         send_steady = (phase == 4);
         rsp_steady  = (phase == 4);
         repeat (130) begin
            if ($urandom_range(0, 5) == 0)
               send_item(rand_entry(SlotWidth'($urandom_range(0, MaxEntries - 1))));
            else
               send_item(rand_lookup());
         end
         wait_idle();
      end
      send_steady = 1'b0;
      rsp_steady  = 1'b0;
   endtask

   // Long response hold-off while lookups keep coming: the chain fills and stalls
   task automatic test_output_stall();
      send_steady  = 1'b1;
      hold_request = 80;
      repeat (60) send_item(rand_lookup());
      send_steady = 1'b0;
      wait_idle();
   endtask

   // Sender goes quiet until all responses are back, then resumes
   task automatic test_paused_sender();
      repeat (40) send_item(rand_lookup());
      wait_idle();
      repeat (40) begin
         if ($urandom_range(0, 4) == 0)
            send_item(rand_entry(SlotWidth'($urandom_range(0, MaxEntries - 1))));
         else
            send_item(rand_lookup());
      end
   endtask

   initial begin
      reset                    <= 1'b1;
      req_bus.valid            <= 1'b0;
      req_bus.func             <= FUNC_WRITE;
      req_bus.entry_index      <= '0;
      req_bus.entry_domain     <= '0;
      req_bus.entry_prefix     <= '0;
      req_bus.entry_deny       <= 1'b0;
      req_bus.entry_range      <= '0;
      req_bus.entry_address    <= '0;
      req_bus.entry_netmask    <= '0;
      req_bus.query_domain     <= '0;
      req_bus.query_any_domain <= 1'b0;
      req_bus.query_address    <= '0;
      csr_write_enable         <= 1'b0;
      csr_index                <= CSR_ENTRY_COUNT;
      csr_write_data           <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_default_answer();
      test_load_table();
      test_priority_cases();
      test_count_limits();
      test_spare_registers();
      test_random_traffic();
      test_output_stall();
      test_paused_sender();
      wait_idle();

      if (errors == 0 && pending_verdicts.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/ipacl_pkg.sv
src/ipacl_if.sv
src/ipacl_cell.sv
src/ip_acl_longest_prefix_match.sv
src/ipacl_checker.sv
tb/ip_acl_longest_prefix_match_tb.sv
